FILE: rtl/core/bbcr_pkg.sv
// package for the bang-bang clock recovery loop
// holds register indexes, reset values, field widths and the shared structs
// no dependencies
package bbcr_pkg;

  localparam int unsigned BASE_INC_W   = 32;
  localparam int unsigned LOOP_GAIN_W  = 16;
  localparam int unsigned WINDOW_LEN_W = 6;
  localparam int unsigned LEAK_SHIFT_W = 4;
  localparam int unsigned PHASE_INIT_W = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam int unsigned PHASE_ERR_W  = 16;
  localparam int unsigned S_TDATA_W    = 8;
  localparam int unsigned M_TDATA_W    = 24;

  localparam logic [BASE_INC_W-1:0]   BASE_INC_RST   = 32'd42949673;
  localparam logic [LOOP_GAIN_W-1:0]  LOOP_GAIN_RST  = 16'd655;
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RST = 6'd40;
  localparam logic [LEAK_SHIFT_W-1:0] LEAK_SHIFT_RST = 4'd10;
  localparam logic [PHASE_INIT_W-1:0] PHASE_INIT_RST = 32'd858993459;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_INC   = 3'd0,
    REG_LOOP_GAIN  = 3'd1,
    REG_WINDOW_LEN = 3'd2,
    REG_LEAK_SHIFT = 3'd3,
    REG_PHASE_INIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [BASE_INC_W-1:0]   base_inc;
    logic [LOOP_GAIN_W-1:0]  loop_gain;
    logic [WINDOW_LEN_W-1:0] window_len;
    logic [LEAK_SHIFT_W-1:0] leak_shift;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_ERR_W-1:0] phase_error;
    logic                   clock_window;
    logic                   data_window;
    logic                   rec_clock;
  } res_t;

endpackage

FILE: rtl/core/bang_bang_clock_recovery_pll_top.sv
// Bang-bang clock recovery loop. One data sample is taken per cycle while the result
// register is free or being drained, and one result leaves per sample; each sample passes
// the input register, then the result register, with the loop update (nco multiply-add,
// window counters and leaky filter) between the two registers.
// The nco starts from the phase_init reset value; later phase_init writes do not move it.
// Depends on bbcr_pkg, bbcr_cfg_regs and bbcr_loop.
module bang_bang_clock_recovery_pll_top
  import bbcr_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned ERROR_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] data_bit, rest zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] rec_clock, [1] data_window,
                                                // [2] clock_window, [18:3] phase_error
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;
  res_t res;

  logic                 in_valid_d, in_valid_q, in_data_q;
  logic                 out_valid_d, out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 advance, in_req;

  bbcr_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  bbcr_loop #(
    .PHASE_BITS (PHASE_BITS),
    .ERROR_BITS (ERROR_BITS)
  ) u_loop (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .step_i (advance),
    .data_i (in_data_q),
    .res_o  (res)
  );

  // a sample moves on when the result register is free or being drained
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_req        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d  = in_req | (in_valid_q & ~advance);
    out_valid_d = advance | (out_valid_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      in_data_q <= s_axis_tdata[0];
    end
    if (advance) begin
      out_data_q <= M_TDATA_W'(res);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/bbcr_cfg_regs.sv
// configuration register file of the clock recovery loop
// depends on bbcr_pkg
module bbcr_cfg_regs
  import bbcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_BASE_INC:   cfg_d.base_inc   = cfg_wdata_i[BASE_INC_W-1:0];
        REG_LOOP_GAIN:  cfg_d.loop_gain  = cfg_wdata_i[LOOP_GAIN_W-1:0];
        REG_WINDOW_LEN: cfg_d.window_len = cfg_wdata_i[WINDOW_LEN_W-1:0];
        REG_LEAK_SHIFT: cfg_d.leak_shift = cfg_wdata_i[LEAK_SHIFT_W-1:0];
        // phase init only matters at reset, so a write has no effect
        REG_PHASE_INIT: cfg_d = cfg_q;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_inc   <= BASE_INC_RST;
      cfg_q.loop_gain  <= LOOP_GAIN_RST;
      cfg_q.window_len <= WINDOW_LEN_RST;
      cfg_q.leak_shift <= LEAK_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/bbcr_loop.sv
// loop state registers and combinational update: nco, edge windows, leaky phase filter
// depends on bbcr_pkg
module bbcr_loop
  import bbcr_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned ERROR_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  logic data_i,
  output res_t res_o
);

  localparam int unsigned PROD_W = ERROR_BITS + LOOP_GAIN_W + 1;
  localparam int unsigned SUM_W  = (PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W;
  localparam int unsigned EXT_W  = (PHASE_BITS > BASE_INC_W) ? PHASE_BITS : BASE_INC_W;
  localparam int unsigned FW     = ERROR_BITS + 2;
  localparam int unsigned OW     = (ERROR_BITS > PHASE_ERR_W) ? ERROR_BITS : PHASE_ERR_W;

  localparam logic signed [ERROR_BITS-1:0] ERR_MAX = {1'b0, {(ERROR_BITS-1){1'b1}}};
  localparam logic signed [ERROR_BITS-1:0] ERR_MIN = {1'b1, {(ERROR_BITS-1){1'b0}}};
  localparam logic [EXT_W-1:0]             INIT_EXT = EXT_W'(PHASE_INIT_RST);

  logic [PHASE_BITS-1:0]         phase_d, phase_q;
  logic                          dprev_q, cprev_q;
  logic [WINDOW_LEN_W-1:0]       dcnt_d, dcnt_q, ccnt_d, ccnt_q;
  logic signed [ERROR_BITS-1:0]  fe_d, fe_q;

  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       prod_ext;
  logic [EXT_W-1:0]              base_ext;
  logic                          clk_bit, dedge, cedge, dwin, cwin, early;
  logic signed [ERROR_BITS-1:0]  fe_hit, fe_miss;
  logic signed [OW-1:0]          fe_out;

  // move err toward tgt by (tgt - err) >>> sh, clamped to the error range
  function automatic logic signed [ERROR_BITS-1:0] leak(
    input logic signed [ERROR_BITS-1:0] tgt,
    input logic signed [ERROR_BITS-1:0] err,
    input logic [LEAK_SHIFT_W-1:0]      sh
  );
    logic signed [FW-1:0] diff;
    logic signed [FW-1:0] sum;
    diff = FW'(tgt) - FW'(err);
    sum  = FW'(err) + (diff >>> sh);
    if (sum > FW'(ERR_MAX)) begin
      leak = ERR_MAX;
    end else if (sum < FW'(ERR_MIN)) begin
      leak = ERR_MIN;
    end else begin
      leak = sum[ERROR_BITS-1:0];
    end
  endfunction

  // nco advance with the error of the previous tick
  always_comb begin
    prod     = $signed({1'b0, cfg_i.loop_gain}) * fe_q;
    prod_ext = SUM_W'(prod);
    base_ext = EXT_W'(cfg_i.base_inc);
    phase_d  = phase_q + base_ext[PHASE_BITS-1:0] + prod_ext[PHASE_BITS-1:0];
    clk_bit  = phase_d[PHASE_BITS-1];
  end

  // edge windows
  always_comb begin
    dedge = data_i & ~dprev_q;
    dwin  = dedge | (dcnt_q != '0);
    if (dedge) begin
      dcnt_d = cfg_i.window_len;
    end else if (dcnt_q != '0) begin
      dcnt_d = dcnt_q - 1'b1;
    end else begin
      dcnt_d = dcnt_q;
    end

    cedge = clk_bit ^ cprev_q;
    cwin  = cedge | (ccnt_q != '0);
    if (cedge) begin
      ccnt_d = cfg_i.window_len;
    end else if (ccnt_q != '0) begin
      ccnt_d = ccnt_q - 1'b1;
    end else begin
      ccnt_d = ccnt_q;
    end
  end

  // both filter outcomes are ready before the clock window settles
  always_comb begin
    early   = dcnt_d < (cfg_i.window_len >> 1);
    fe_hit  = leak(early ? ERR_MAX : ERR_MIN, fe_q, cfg_i.leak_shift);
    fe_miss = leak('0, fe_q, cfg_i.leak_shift);
    if (!dwin) begin
      fe_d = fe_q;
    end else if (cwin) begin
      fe_d = fe_hit;
    end else begin
      fe_d = fe_miss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= INIT_EXT[PHASE_BITS-1:0];
      dprev_q <= 1'b0;
      cprev_q <= 1'b0;
      dcnt_q  <= '0;
      ccnt_q  <= '0;
      fe_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dprev_q <= data_i;
      cprev_q <= clk_bit;
      dcnt_q  <= dcnt_d;
      ccnt_q  <= ccnt_d;
      fe_q    <= fe_d;
    end
  end

  assign fe_out             = OW'(fe_d);
  assign res_o.rec_clock    = clk_bit;
  assign res_o.data_window  = dwin;
  assign res_o.clock_window = cwin;
  assign res_o.phase_error  = fe_out[PHASE_ERR_W-1:0];

endmodule

FILE: rtl/core/bbcr_checker.sv
// port-level checks for the clock recovery loop, bound to the top level
// depends on bbcr_pkg and bang_bang_clock_recovery_pll_top
module bbcr_checker
  import bbcr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // input only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // padding bits of a result are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:PHASE_ERR_W+3] == '0))
    else $error("nonzero padding in result");

endmodule

bind bang_bang_clock_recovery_pll_top bbcr_checker u_bbcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
